### design/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types, codes and the CRC16-CCITT byte update for the frame receiver.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int MAX_LEN   = 16;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int CNT_W     = (LEN_W > 2) ? LEN_W : 2;
    localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        ACT_SEND   = 3'd0,
        ACT_WRITE  = 3'd1,
        ACT_JUMP   = 3'd2,
        ACT_UNLOCK = 3'd3,
        ACT_LOCK   = 3'd4
    } t_action;

    localparam logic [7:0] CODE_TRIG = 8'h7F;
    localparam logic [7:0] CODE_ACK  = 8'h79;
    localparam logic [7:0] CODE_NACK = 8'h1F;
    localparam logic [7:0] CODE_END  = 8'hFF;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [23:0] APP_START_RST = 24'h008400;
    localparam logic [23:0] FLASH_END_RST = 24'h00A000;

    localparam logic [CFG_IDX_W-1:0] CFG_APP_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_END = CFG_IDX_W'(1);

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### design/bootloader_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// bootloader_frame_receiver_top
// Serial firmware-update frame receiver with CRC16-CCITT check.
// ----------------------------------------------------------------------------
// An input item is taken whenever the receiver is idle, even while a result
// is still held in the output register. Each item passes through the execute
// step; items that cause results then emit one result per cycle through the
// output register while downstream accepts. The closing CRC byte of a good
// frame yields one write per data byte and a closing ACK; the data bytes are
// read back from the frame data RAM one entry a cycle.
// Downstream back-pressure stretches the emit phase.
module bootloader_frame_receiver_top
    import bfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_kind,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_action,
    output logic [7:0]           o_tx_byte,
    output logic [23:0]          o_flash_addr,
    output logic [7:0]           o_flash_data,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_EMIT} t_state;

    typedef enum logic [2:0] {
        PH_HANDSHAKE, PH_START, PH_HEADER, PH_DATA, PH_CRC_HI, PH_CRC_LO, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        PL_ACK_UNLOCK, PL_NACK, PL_ACK_LOCK_JUMP, PL_JUMP, PL_WRITES
    } t_plan;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    t_plan             r_plan, n_plan;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [23:0]       r_faddr, n_faddr;
    logic [LEN_W-1:0]  r_flen, n_flen;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_crc_hi, n_crc_hi;
    logic [LEN_W-1:0]  r_step, n_step;
    logic              r_kind;
    logic [7:0]        r_byte;
    logic [23:0]       r_app_start, r_flash_end;

    logic              r_out_valid, n_out_valid;
    t_action           r_action, n_action;
    logic [7:0]        r_tx, n_tx;
    logic [23:0]       r_oaddr, n_oaddr;
    logic [7:0]        r_odata, n_odata;
    logic              r_last, n_last;

    logic              in_acc;
    logic              out_load;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [7:0]        ram_rdata;
    logic [15:0]       crc_next;
    logic [CNT_W-1:0]  cnt_inc;
    logic              frame_ok;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_load  = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign crc_next  = crc_feed((r_phase == PH_START) ? CRC_INIT : r_crc, r_byte);
    assign cnt_inc   = r_cnt + CNT_W'(1);
    assign ram_waddr = r_cnt[IDX_W-1:0];
    assign frame_ok  = ({r_crc_hi, r_byte} == r_crc) && (r_faddr >= r_app_start)
                       && (({1'b0, r_faddr} + 25'(r_flen)) <= {1'b0, r_flash_end});

    bfr_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_byte),
        .i_raddr (n_step[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_plan   = r_plan;
        n_cnt    = r_cnt;
        n_faddr  = r_faddr;
        n_flen   = r_flen;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        n_step   = r_step;
        ram_we   = 1'b0;

        n_out_valid = r_out_valid && !i_out_ready;
        n_action    = r_action;
        n_tx        = r_tx;
        n_oaddr     = r_oaddr;
        n_odata     = r_odata;
        n_last      = r_last;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_step  = '0;
                if (r_phase == PH_HANDSHAKE) begin
                    if (r_kind) begin
                        n_plan  = PL_JUMP;
                        n_phase = PH_DONE;
                        n_state = S_EMIT;
                    end else if (r_byte == CODE_TRIG) begin
                        n_plan  = PL_ACK_UNLOCK;
                        n_phase = PH_START;
                        n_cnt   = '0;
                        n_state = S_EMIT;
                    end
                end else if (r_phase != PH_DONE && !r_kind) begin
                    case (r_phase)
                        PH_START: begin
                            if (r_byte == CODE_END) begin
                                n_plan  = PL_ACK_LOCK_JUMP;
                                n_phase = PH_DONE;
                                n_state = S_EMIT;
                            end else begin
                                n_crc   = crc_next;
                                n_faddr = {r_byte, 16'h0000};
                                n_cnt   = CNT_W'(1);
                                n_phase = PH_HEADER;
                            end
                        end
                        PH_HEADER: begin
                            n_crc = crc_next;
                            if (r_cnt == CNT_W'(1)) begin
                                n_faddr[15:8] = r_byte;
                                n_cnt         = CNT_W'(2);
                            end else if (r_cnt == CNT_W'(2)) begin
                                n_faddr[7:0] = r_byte;
                                n_cnt        = CNT_W'(3);
                            end else if (r_byte == 8'h00 || r_byte > 8'(MAX_LEN)) begin
                                n_plan  = PL_NACK;
                                n_phase = PH_START;
                                n_cnt   = '0;
                                n_state = S_EMIT;
                            end else begin
                                n_flen  = r_byte[LEN_W-1:0];
                                n_cnt   = '0;
                                n_phase = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            n_crc  = crc_next;
                            ram_we = 1'b1;
                            n_cnt  = cnt_inc;
                            if (cnt_inc >= CNT_W'(r_flen)) begin
                                n_phase = PH_CRC_HI;
                            end
                        end
                        PH_CRC_HI: begin
                            n_crc_hi = r_byte;
                            n_phase  = PH_CRC_LO;
                        end
                        PH_CRC_LO: begin
                            n_plan  = frame_ok ? PL_WRITES : PL_NACK;
                            n_phase = PH_START;
                            n_cnt   = '0;
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_step      = r_step + LEN_W'(1);
                    n_tx        = 8'h00;
                    n_oaddr     = 24'h000000;
                    n_odata     = 8'h00;
                    n_last      = 1'b0;
                    case (r_plan)
                        PL_ACK_UNLOCK: begin
                            if (r_step == '0) begin
                                n_action = ACT_SEND;
                                n_tx     = CODE_ACK;
                            end else begin
                                n_action = ACT_UNLOCK;
                                n_last   = 1'b1;
                            end
                        end
                        PL_NACK: begin
                            n_action = ACT_SEND;
                            n_tx     = CODE_NACK;
                            n_last   = 1'b1;
                        end
                        PL_ACK_LOCK_JUMP: begin
                            if (r_step == '0) begin
                                n_action = ACT_SEND;
                                n_tx     = CODE_ACK;
                            end else if (r_step == LEN_W'(1)) begin
                                n_action = ACT_LOCK;
                            end else begin
                                n_action = ACT_JUMP;
                                n_last   = 1'b1;
                            end
                        end
                        PL_JUMP: begin
                            n_action = ACT_JUMP;
                            n_last   = 1'b1;
                        end
                        PL_WRITES: begin
                            if (r_step < r_flen) begin
                                n_action = ACT_WRITE;
                                n_oaddr  = r_faddr + 24'(r_step);
                                n_odata  = ram_rdata;
                            end else begin
                                n_action = ACT_SEND;
                                n_tx     = CODE_ACK;
                                n_last   = 1'b1;
                            end
                        end
                        default: begin
                            n_action = ACT_JUMP;
                            n_last   = 1'b1;
                        end
                    endcase
                    if (n_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_HANDSHAKE;
            r_plan      <= PL_NACK;
            r_cnt       <= '0;
            r_faddr     <= '0;
            r_flen      <= '0;
            r_crc       <= CRC_INIT;
            r_crc_hi    <= '0;
            r_step      <= '0;
            r_app_start <= APP_START_RST;
            r_flash_end <= FLASH_END_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_plan      <= n_plan;
            r_cnt       <= n_cnt;
            r_faddr     <= n_faddr;
            r_flen      <= n_flen;
            r_crc       <= n_crc;
            r_crc_hi    <= n_crc_hi;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_APP_START) begin
                    r_app_start <= i_cfg_data;
                end else if (i_cfg_index == CFG_FLASH_END) begin
                    r_flash_end <= i_cfg_data;
                end
            end
        end
        if (in_acc) begin
            r_kind <= i_kind;
            r_byte <= i_rx_byte;
        end
        r_action <= n_action;
        r_tx     <= n_tx;
        r_oaddr  <= n_oaddr;
        r_odata  <= n_odata;
        r_last   <= n_last;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_action     = r_action;
    assign o_tx_byte    = r_tx;
    assign o_flash_addr = r_oaddr;
    assign o_flash_data = r_odata;
    assign o_last       = r_last;

`ifndef ASSERT_OFF
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_state == S_EMIT))
        else $error("non-final item shown with no emission in progress");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("receiver left the done phase");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_plan == PL_WRITES) |-> (r_step <= r_flen))
        else $error("write step ran past frame length");
`endif

endmodule

### design/bfr_ram.sv
// ----------------------------------------------------------------------------
// bfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
